/* sv/aosd_pkg.sv */
// Shared types and constants for the accelerometer orientation, scale and deadband unit.
// Holds the mounting remap table, the scale constant and the configuration indexes.
// No dependencies.
`timescale 1ns / 1ps

package aosd_pkg;

   // Configuration register indexes.
   localparam logic CSR_MOUNT_ORIENTATION = 1'b0;
   localparam logic CSR_CHANGE_THRESHOLD  = 1'b1;

   localparam int ORIENT_W    = 3;
   localparam int THRESHOLD_W = 25;
   localparam int RAW_W       = 10;
   localparam int ACCEL_W     = 26;
   localparam int PROD_W      = 34;
   localparam int DIFF_W      = ACCEL_W + 1;
   localparam int RES_SHIFT   = 8;

   // Standard gravity in micrometres per second squared, applied per 256 raw counts.
   localparam logic signed [PROD_W-1:0] GRAVITY_UM = 34'sd9806550;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = 34'sd255;

   // Axis codes used as remap sources.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // One mounting remap: for each output axis, which sample feeds it and whether it is negated.
   typedef struct packed {
      logic [2:0][1:0] src;
      logic [2:0]      neg;
   } remap_type;

   function automatic remap_type remap_lookup(input logic [ORIENT_W-1:0] orient);
      remap_type r;
      r.src = {AXIS_Z, AXIS_Y, AXIS_X};
      r.neg = 3'b000;
      case (orient)
         3'd0: begin
            r.src = {AXIS_Z, AXIS_X, AXIS_Y};
            r.neg = 3'b001;
         end
         3'd1: begin
            r.src = {AXIS_Z, AXIS_Y, AXIS_X};
            r.neg = 3'b000;
         end
         3'd2: begin
            r.src = {AXIS_Z, AXIS_X, AXIS_Y};
            r.neg = 3'b010;
         end
         3'd3: begin
            r.src = {AXIS_Z, AXIS_Y, AXIS_X};
            r.neg = 3'b011;
         end
         3'd4: begin
            r.src = {AXIS_Z, AXIS_X, AXIS_Y};
            r.neg = 3'b100;
         end
         3'd5: begin
            r.src = {AXIS_Z, AXIS_Y, AXIS_X};
            r.neg = 3'b101;
         end
         3'd6: begin
            r.src = {AXIS_Z, AXIS_X, AXIS_Y};
            r.neg = 3'b111;
         end
         3'd7: begin
            r.src = {AXIS_Z, AXIS_Y, AXIS_X};
            r.neg = 3'b110;
         end
         default: begin
            r.src = {AXIS_Z, AXIS_Y, AXIS_X};
            r.neg = 3'b000;
         end
      endcase
      return r;
   endfunction

endpackage

/* sv/accel_orient_scale_deadband_unit.sv */
// Top level of the accelerometer orientation, scale and deadband unit.
// Depends on aosd_pkg for the remap table, the scale constant and the register indexes.
`timescale 1ns / 1ps

// Usage.
// The req_ channel carries one accelerometer frame per request: six raw register bytes in
// req_tdata and the bus read status in req_tuser. The rsp_ channel returns one result per
// request: the three reported axes in micrometres per second squared in rsp_tdata and the
// changed flag in rsp_tuser. The csr_ channel writes the mounting orientation (index 0) and
// the deadband threshold (index 1); it is always ready and must only be used while idle.
// The datapath is three registers deep: an input register, a scale register holding each
// sample times gravity over 256, and the result register, where the remap, the deadband
// compare against the last reported value and the state update happen together.
// One request is accepted every cycle while the receiver keeps taking results; the single
// multiply per axis and the deadband compare each own one stage.
// When the receiver stalls, results stay in the result register and the earlier stages keep
// filling until every stage holds a request; only then does req_tready drop.
// Reset (synchronous, active high) empties the pipeline, clears the last reported values
// to zero and sets both configuration registers to zero.
module accel_orient_scale_deadband_unit (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // Bits from low: x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte.
   input  logic [47:0] req_tdata,
   // Bit 0: read_ok.
   input  logic [0:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Bits from low: out_x [25:0], out_y [51:26], out_z [77:52], zero fill [79:78].
   output logic [79:0] rsp_tdata,
   // Bit 0: changed.
   output logic [0:0]  rsp_tuser,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [24:0] csr_wdata
);

   localparam int AW = aosd_pkg::ACCEL_W;
   localparam int DW = aosd_pkg::DIFF_W;

   // Configuration registers.
   logic [aosd_pkg::ORIENT_W-1:0]    orient_ff;
   logic [aosd_pkg::THRESHOLD_W-1:0] threshold_ff;

   // Input stage.
   logic        a_valid_ff;
   logic [47:0] a_bytes_ff;
   logic        a_ok_ff;

   // Scale stage: each raw sample already multiplied by gravity over 256.
   logic                           b_valid_ff;
   logic signed [2:0][AW-1:0]      b_scaled_ff;
   logic signed [2:0][AW-1:0]      b_scaled_in;

   // Result stage and last reported values.
   logic                           rsp_valid_ff;
   logic signed [2:0][AW-1:0]      rsp_axes_ff;
   logic signed [2:0][AW-1:0]      rsp_axes_in;
   logic                           rsp_changed_ff;
   logic                           rsp_changed_in;

   logic ready_c;
   logic ready_b;
   logic ready_a;
   logic load_a;
   logic load_b;
   logic load_c;

   // A stage moves forward when the next one is empty or also moving.
   assign ready_c    = !rsp_valid_ff || rsp_tready;
   assign ready_b    = !b_valid_ff || ready_c;
   assign ready_a    = !a_valid_ff || ready_b;
   assign req_tready = ready_a;
   assign load_a     = req_tvalid && ready_a;
   assign load_b     = a_valid_ff && ready_b;
   assign load_c     = b_valid_ff && ready_c;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff    <= '0;
         threshold_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            aosd_pkg::CSR_MOUNT_ORIENTATION: orient_ff    <= csr_wdata[aosd_pkg::ORIENT_W-1:0];
            aosd_pkg::CSR_CHANGE_THRESHOLD:  threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (ready_a) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_bytes_ff <= req_tdata;
         a_ok_ff    <= req_tuser[0];
      end
   end

   // Each 16-bit word shifted right arithmetically by 6 keeps its top ten bits. Scaling by
   // gravity over 256 truncates toward zero, so negative products get a bias before the shift.
   always_comb begin
      logic signed [aosd_pkg::RAW_W-1:0]  raw;
      logic signed [aosd_pkg::PROD_W-1:0] prod;
      logic signed [aosd_pkg::PROD_W-1:0] biased;
      for (int i = 0; i < 3; i++) begin
         raw = a_ok_ff ? $signed(a_bytes_ff[16*i+15 -: aosd_pkg::RAW_W]) : '0;
         prod = aosd_pkg::PROD_W'(raw) * aosd_pkg::GRAVITY_UM;
         biased = prod + (prod[aosd_pkg::PROD_W-1] ? aosd_pkg::ROUND_BIAS : '0);
         b_scaled_in[i] = biased[aosd_pkg::RES_SHIFT +: AW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (ready_b) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_b) begin
         b_scaled_ff <= b_scaled_in;
      end
   end

   // Remap, then deadband against the last reported values. The fresh x is compared as is,
   // although the stored x holds the negated value that was reported.
   always_comb begin
      aosd_pkg::remap_type          map;
      logic signed [2:0][AW-1:0]    data;
      logic signed [DW-1:0]         diff;
      logic        [DW-1:0]         mag;
      logic                         exceed;
      map    = aosd_pkg::remap_lookup(orient_ff);
      exceed = 1'b0;
      for (int i = 0; i < 3; i++) begin
         data[i] = map.neg[i] ? -b_scaled_ff[map.src[i]] : b_scaled_ff[map.src[i]];
         // Elements of a packed array are unsigned, so each axis is sign extended explicitly.
         diff    = DW'($signed(rsp_axes_ff[i])) - DW'($signed(data[i]));
         mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
         if (mag > DW'(threshold_ff)) begin
            exceed = 1'b1;
         end
      end
      rsp_changed_in = exceed;
      if (exceed) begin
         rsp_axes_in[0] = -data[0];
         rsp_axes_in[1] = data[1];
         rsp_axes_in[2] = data[2];
      end else begin
         rsp_axes_in = rsp_axes_ff;
      end
   end

   // The result register doubles as the last reported state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         rsp_axes_ff    <= '0;
         rsp_changed_ff <= 1'b0;
      end else begin
         if (ready_c) begin
            rsp_valid_ff <= b_valid_ff;
         end
         if (load_c) begin
            rsp_axes_ff    <= rsp_axes_in;
            rsp_changed_ff <= rsp_changed_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_axes_ff[2], rsp_axes_ff[1], rsp_axes_ff[0]};
   assign rsp_tuser  = rsp_changed_ff;

endmodule

/* verif/tb_accel_orient_scale_deadband_unit.sv */
// Self-checking testbench for accel_orient_scale_deadband_unit: drives accelerometer frames,
// predicts every reported reading and checks the response stream field by field.
// Depends on aosd_pkg for the configuration register indexes and on the unit itself.
`timescale 1ns / 1ps

module tb_accel_orient_scale_deadband_unit;

   // Standard gravity in um/s^2 and the raw counts that make up one g.
   localparam longint STD_GRAVITY  = 9806550;
   localparam longint COUNTS_PER_G = 256;
   // Largest threshold the deadband register accepts, and the top of the documented range.
   localparam logic [24:0] THR_ALL_ONES = 25'h1FFFFFF;
   localparam logic [24:0] THR_FULL_SCALE = 25'd19613100;
   // One raw count after scaling; used to put the threshold right on a step boundary.
   localparam logic [24:0] THR_ONE_COUNT = 25'd38306;
   // Length of the one hold in which the receiver stops taking responses, to back up the pipeline.
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int LONG_HOLD_AFTER  = 300;
   localparam int RANDOM_PHASES    = 16;
   localparam int FRAMES_PER_PHASE = 90;

   // One reported reading as the unit returns it.
   typedef struct {
      logic [25:0] x;
      logic [25:0] y;
      logic [25:0] z;
      logic        changed;
   } accel_reading_type;

   // Holds its own copy of the orientation, threshold and last reported values, turns every
   // accepted frame into the reading the unit must report, and compares responses in order.
   class accel_scoreboard_type;
      logic [2:0]        orient;
      logic [24:0]       threshold;
      longint            last_x, last_y, last_z;
      accel_reading_type expected_readings[$];
      int                errors;

      function new();
         orient    = 3'd0;
         threshold = 25'd0;
         last_x    = 0;
         last_y    = 0;
         last_z    = 0;
         errors    = 0;
      endfunction

      function void write_reg(logic idx, logic [24:0] value);
         if (idx == aosd_pkg::CSR_MOUNT_ORIENTATION)
            orient = value[2:0];
         else
            threshold = value;
      endfunction

      // 16-bit word shifted right arithmetically by 6: a 10-bit signed sample.
      function longint raw_sample(logic [15:0] word);
         logic signed [15:0] s;
         s = word;
         return s >>> 6;
      endfunction

      function longint distance(longint a, longint b);
         return (a > b) ? a - b : b - a;
      endfunction

      function void note_frame(logic [15:0] wx, logic [15:0] wy, logic [15:0] wz,
                               logic ok);
         longint rx, ry, rz, ax, ay, az;
         bit moved;
         accel_reading_type r;
         rx = 0;
         ry = 0;
         rz = 0;
         // A failed bus read reports a zero vector, whatever the bytes hold.
         if (ok) begin
            rx = raw_sample(wx);
            ry = raw_sample(wy);
            rz = raw_sample(wz);
         end
         // Mounting remap: each orientation is a signed permutation of the chip axes.
         case (orient)
            3'd0: begin ax = -ry; ay =  rx; az =  rz; end
            3'd1: begin ax =  rx; ay =  ry; az =  rz; end
            3'd2: begin ax =  ry; ay = -rx; az =  rz; end
            3'd3: begin ax = -rx; ay = -ry; az =  rz; end
            3'd4: begin ax =  ry; ay =  rx; az = -rz; end
            3'd5: begin ax = -rx; ay =  ry; az = -rz; end
            3'd6: begin ax = -ry; ay = -rx; az = -rz; end
            default: begin ax = rx; ay = -ry; az = -rz; end
         endcase
         // SystemVerilog integer division truncates toward zero, as the unit must.
         ax = ax * STD_GRAVITY / COUNTS_PER_G;
         ay = ay * STD_GRAVITY / COUNTS_PER_G;
         az = az * STD_GRAVITY / COUNTS_PER_G;
         // The fresh x is compared as is against the stored x, which was kept negated.
         moved = distance(last_x, ax) > longint'(threshold) ||
                 distance(last_y, ay) > longint'(threshold) ||
                 distance(last_z, az) > longint'(threshold);
         if (moved) begin
            last_x = -ax;
            last_y = ay;
            last_z = az;
         end
         r.x       = last_x[25:0];
         r.y       = last_y[25:0];
         r.z       = last_z[25:0];
         r.changed = moved;
         expected_readings.push_back(r);
      endfunction

      function void check_reading(logic [79:0] data, logic changed);
         accel_reading_type e;
         if (expected_readings.size() == 0) begin
            $display("%0t: response with no request outstanding: data %h changed %b",
                     $time, data, changed);
            errors++;
            return;
         end
         e = expected_readings.pop_front();
         if (data[25:0] !== e.x) begin
            $display("%0t: out_x expected %0d actual %0d", $time,
                     $signed(e.x), $signed(data[25:0]));
            errors++;
         end
         if (data[51:26] !== e.y) begin
            $display("%0t: out_y expected %0d actual %0d", $time,
                     $signed(e.y), $signed(data[51:26]));
            errors++;
         end
         if (data[77:52] !== e.z) begin
            $display("%0t: out_z expected %0d actual %0d", $time,
                     $signed(e.z), $signed(data[77:52]));
            errors++;
         end
         if (changed !== e.changed) begin
            $display("%0t: changed expected %b actual %b", $time, e.changed, changed);
            errors++;
         end
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // Bits from low: x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte.
   logic [47:0] req_tdata;
   // Bit 0: read_ok.
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // Bits from low: out_x, out_y, out_z, two bits of zero fill.
   logic [79:0] rsp_tdata;
   // Bit 0: changed.
   logic [0:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [24:0] csr_wdata;

   accel_scoreboard_type sb = new();

   int          burst_left = 0;
   int          responses_seen = 0;
   int          hold_left = 0;
   bit          hold_done = 0;
   logic [31:0] rcv_cycle = '0;

   accel_orient_scale_deadband_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The run ends here if the handshakes ever stop moving.
   initial begin
      #(10_000_000);
      $display("Simulation FAILED");
      $finish;
   end

   // Every accepted response is checked against the oldest predicted reading.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_reading(rsp_tdata, rsp_tuser[0]);
         responses_seen <= responses_seen + 1;
      end
   end

   // Receiver. It steps through four kinds of window in turn: always ready, a fixed one-in-five
   // stall, coin-flip stalls and light random stalls. Once, after a few hundred responses,
   // it holds off for a long stretch so the pipeline fills and the request side stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && responses_seen >= LONG_HOLD_AFTER) begin
         hold_done  <= 1'b1;
         hold_left  <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rcv_cycle <= rcv_cycle + 1;
         case (rcv_cycle[8:7])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= (rcv_cycle % 5) != 0;
            2'd2: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= $urandom_range(0, 4) != 0;
         endcase
      end
   end

   // Offers one frame and returns once it has been accepted. Frames go out in bursts of
   // random length; a random gap (possibly none) comes before each new burst. Ready is
   // sampled on the falling edge, where nothing the bench drives is changing.
   task automatic send_frame(input logic [15:0] wx, input logic [15:0] wy,
                             input logic [15:0] wz, input logic ok);
      int   gap;
      logic hs;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wz, wy, wx};
      req_tuser  <= ok;
      do begin
         @(negedge clock);
         hs = req_tready;
         @(posedge clock);
      end while (!hs);
      sb.note_frame(wx, wy, wz, ok);
      burst_left--;
   endtask

   // Stops offering requests and waits until every predicted reading has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Writes both registers back to back; only called while the unit is idle.
   task automatic configure(input logic [2:0] orient, input logic [24:0] threshold);
      logic hs;
      csr_valid <= 1'b1;
      csr_index <= aosd_pkg::CSR_MOUNT_ORIENTATION;
      csr_wdata <= {22'd0, orient};
      do begin
         @(negedge clock);
         hs = csr_ready;
         @(posedge clock);
      end while (!hs);
      sb.write_reg(aosd_pkg::CSR_MOUNT_ORIENTATION, {22'd0, orient});
      csr_index <= aosd_pkg::CSR_CHANGE_THRESHOLD;
      csr_wdata <= threshold;
      do begin
         @(negedge clock);
         hs = csr_ready;
         @(posedge clock);
      end while (!hs);
      sb.write_reg(aosd_pkg::CSR_CHANGE_THRESHOLD, threshold);
      csr_valid <= 1'b0;
   endtask

   // Next raw word for one axis. Small steps around the previous word keep the deadband
   // busy on both sides of the threshold; full random words and the range corners make
   // the large jumps.
   function automatic logic [15:0] pick_word(input logic [15:0] prev, input int mode);
      int          step;
      logic [15:0] w;
      if (mode < 6) begin
         step    = $urandom_range(0, 8) - 4;
         w       = prev + 16'(step * 64);
         w[5:0]  = 6'($urandom_range(0, 63));
      end else if (mode < 9) begin
         w = 16'($urandom_range(0, 65535));
      end else begin
         case ($urandom_range(0, 3))
            0: w = 16'h7FFF;
            1: w = 16'h8000;
            2: w = 16'hFFC0;
            default: w = 16'h0000;
         endcase
      end
      return w;
   endfunction

   initial begin
      logic [15:0] wx, wy, wz;
      logic [24:0] thr;
      int          mode;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = 1'b0;
      csr_wdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity mounting, zero threshold: range corners, truncation toward zero on small
      // negative samples, the negated-x compare on a repeated frame, and failed reads.
      configure(3'd1, 25'd0);
      send_frame(16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
      send_frame(16'h8000, 16'h8000, 16'h8000, 1'b1);
      send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_frame(16'h003F, 16'h0040, 16'hFFBF, 1'b1);
      send_frame(16'hFFC0, 16'hFFC0, 16'hFFC0, 1'b1);
      send_frame(16'hFFC0, 16'hFFC0, 16'hFFC0, 1'b1);
      send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_frame(16'h1234, 16'h5678, 16'h9ABC, 1'b0);
      send_frame(16'h0040, 16'h0000, 16'h0000, 1'b1);
      drain();

      // Threshold with every bit set: the output must stay frozen.
      configure(3'd0, THR_ALL_ONES);
      send_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
      send_frame(16'h8000, 16'h8000, 16'h8000, 1'b1);
      send_frame(16'h8000, 16'h7FFF, 16'h0000, 1'b1);
      drain();

      // Full-scale threshold: frames that swing every axis between the range corners.
      configure(3'd7, THR_FULL_SCALE);
      send_frame(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
      send_frame(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
      send_frame(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
      drain();

      // Threshold right at one raw count: equal is not enough, one more count is.
      configure(3'd6, THR_ONE_COUNT);
      send_frame(16'h0000, 16'h0040, 16'h0000, 1'b1);
      send_frame(16'h0000, 16'h0080, 16'h0000, 1'b1);
      send_frame(16'h0000, 16'h00C0, 16'h0040, 1'b1);
      send_frame(16'h0000, 16'hFF80, 16'h0000, 1'b1);
      drain();

      // Random phases: every orientation twice, thresholds from zero to all ones.
      wx = 16'h0000;
      wy = 16'h0000;
      wz = 16'h0000;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 5)
            0: thr = 25'd0;
            1: thr = 25'($urandom_range(0, 100000));
            2: thr = 25'($urandom_range(100000, 2000000));
            3: thr = THR_FULL_SCALE;
            default: thr = 25'($urandom_range(0, THR_ALL_ONES));
         endcase
         configure(3'(p % 8), thr);
         for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
            mode = $urandom_range(0, 9);
            wx = pick_word(wx, mode);
            wy = pick_word(wy, mode);
            wz = pick_word(wz, mode);
            send_frame(wx, wy, wz, $urandom_range(0, 9) != 0);
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
